// File: rtl/core/wbxat_pkg.sv
// shared types, token codes and widths for the wbxml attribute token scanner
`default_nettype none

package wbxat_pkg;

    localparam int DataWidth  = 8;
    localparam int ValueWidth = 32;
    localparam int TallyWidth = 33;
    localparam int KindWidth  = 4;
    localparam int MbiCntWidth = 3;

    // global token bytes in attribute state
    localparam logic [7:0] TokSwitchPage = 8'h00;
    localparam logic [7:0] TokEnd        = 8'h01;
    localparam logic [7:0] TokEntity     = 8'h02;
    localparam logic [7:0] TokStrI       = 8'h03;
    localparam logic [7:0] TokLiteral    = 8'h04;
    localparam logic [7:0] TokExtI0      = 8'h40;
    localparam logic [7:0] TokExtI1      = 8'h41;
    localparam logic [7:0] TokExtI2      = 8'h42;
    localparam logic [7:0] TokExtT0      = 8'h80;
    localparam logic [7:0] TokExtT1      = 8'h81;
    localparam logic [7:0] TokExtT2      = 8'h82;
    localparam logic [7:0] TokStrT       = 8'h83;
    localparam logic [7:0] TokExt0       = 8'hC0;
    localparam logic [7:0] TokExt1       = 8'hC1;
    localparam logic [7:0] TokExt2       = 8'hC2;
    localparam logic [7:0] TokOpaque     = 8'hC3;

    localparam logic [5:0] AttrCodeMin = 6'd5;
    localparam logic [MbiCntWidth-1:0] MbiMaxBytes = 3'd5;
    localparam logic [TallyWidth-1:0]  TallyMax    = '1;

    typedef enum logic [KindWidth-1:0] {
        KIND_SWITCH_PAGE = 4'd0,
        KIND_END         = 4'd1,
        KIND_ENTITY      = 4'd2,
        KIND_STR_I       = 4'd3,
        KIND_LITERAL     = 4'd4,
        KIND_EXT_I       = 4'd5,
        KIND_EXT_T       = 4'd6,
        KIND_STR_T       = 4'd7,
        KIND_EXT_SINGLE  = 4'd8,
        KIND_OPAQUE      = 4'd9,
        KIND_RESERVED    = 4'd10,
        KIND_INVALID     = 4'd11,
        KIND_ATTR_VALUE  = 4'd12,
        KIND_ATTR_START  = 4'd13
    } token_kind_t;

    typedef enum logic [5:0] {
        PH_STOPPED = 6'b000001,
        PH_IDLE    = 6'b000010,
        PH_PAGE    = 6'b000100,
        PH_MBI     = 6'b001000,
        PH_STR     = 6'b010000,
        PH_SKIP    = 6'b100000
    } scan_phase_t;

    typedef struct packed {
        logic                  valid;
        token_kind_t           kind;
        logic [DataWidth-1:0]  code;
        logic [ValueWidth-1:0] value;
        logic [DataWidth-1:0]  page;
        logic [TallyWidth-1:0] bytes;
        logic                  done;
    } scan_result_t;

endpackage

`default_nettype wire

// File: rtl/core/wbxml_attribute_token_scanner.sv
// top level: input register, token state machine, result register, version register
//
// channel  dir  handshake                      payload
// s_axis   in   s_axis_tvalid / s_axis_tready  tdata: data_byte; tuser: start_list
// m_axis   out  m_axis_tvalid / m_axis_tready  tdata: code, value, page, bytes;
//                                              tuser: token_kind; tlast: list_done
// cfg      in   cfg_valid / cfg_ready          cfg_data: version_above_one_zero
//
// one byte per cycle sustained while the result register is not stalled; an item passes
// from the input register through the token state machine into the result register.
// reset clears the token state, code page and handshakes; version resets to 1.
// a stalled result holds the state machine while the input register still takes one item.
`default_nettype none

module wbxml_attribute_token_scanner (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output wire logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_byte [7:0]
    input  wire logic        s_axis_tuser,   // start_list
    output wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output wire logic [87:0] m_axis_tdata,   // token_code [7:0], token_value [39:8],
                                             // code_page [47:40], token_bytes [80:48]
    output wire logic [3:0]  m_axis_tuser,   // token_kind
    output wire logic        m_axis_tlast,   // list_done
    input  wire logic        cfg_valid,
    output wire logic        cfg_ready,
    input  wire logic        cfg_data        // version_above_one_zero
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_start_reg;
    logic        out_valid_reg, out_valid_next;
    logic        version_reg;
    logic        advance;
    logic        s_take;
    wbxat_pkg::scan_result_t result, out_reg;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_take        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    always_comb begin
        in_valid_next = s_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        if (advance && result.valid) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    wbxat_scan_core u_core (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .advance                (advance),
        .data_byte              (in_byte_reg),
        .start_list             (in_start_reg),
        .version_above_one_zero (version_reg),
        .result                 (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            version_reg   <= 1'b1;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                version_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_byte_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser;
        end
        if (advance && result.valid) begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.done;
    assign m_axis_tdata  = {7'd0, out_reg.bytes, out_reg.page, out_reg.value, out_reg.code};

    // list stop only on end, reserved or invalid
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tlast) |->
            (m_axis_tuser == wbxat_pkg::KIND_END || m_axis_tuser == wbxat_pkg::KIND_RESERVED
             || m_axis_tuser == wbxat_pkg::KIND_INVALID))
        else $error("list_done on a token that does not stop the list");

    // every token consumes at least one byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[80:48] != '0))
        else $error("result item with zero token_bytes");

    // attribute value codes always have bit 7 set
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == wbxat_pkg::KIND_ATTR_VALUE) |-> m_axis_tdata[7])
        else $error("attr_value with bit 7 clear");

    // an empty result register never blocks the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with no result pending");

endmodule

`default_nettype wire

// File: rtl/core/wbxat_scan_core.sv
// token state machine: consumes one registered byte and forms the result item
`default_nettype none

module wbxat_scan_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           advance,
    input  wire logic [wbxat_pkg::DataWidth-1:0] data_byte,
    input  wire logic                           start_list,
    input  wire logic                           version_above_one_zero,
    output wbxat_pkg::scan_result_t             result
);

    wbxat_pkg::scan_phase_t phase_reg, phase_next, phase_eff;
    logic [wbxat_pkg::DataWidth-1:0]   held_reg, held_next;
    logic [wbxat_pkg::ValueWidth-1:0]  acc_reg, acc_next, acc_shift;
    logic [wbxat_pkg::ValueWidth-1:0]  rem_reg, rem_next, rem_dec;
    logic [wbxat_pkg::DataWidth-1:0]   page_reg, page_next;
    logic [wbxat_pkg::TallyWidth-1:0]  tally_reg, tally_next, tally_inc;
    logic [wbxat_pkg::MbiCntWidth-1:0] cnt_reg, cnt_next, cnt_inc;
    wbxat_pkg::token_kind_t            mbi_kind;

    always_comb begin
        phase_eff = start_list ? wbxat_pkg::PH_IDLE : phase_reg;
        tally_inc = (tally_reg == wbxat_pkg::TallyMax) ? tally_reg
                                                        : tally_reg + 1'b1;
        acc_shift = {acc_reg[wbxat_pkg::ValueWidth-8:0], data_byte[6:0]};
        cnt_inc   = cnt_reg + 1'b1;
        rem_dec   = (rem_reg != '0) ? rem_reg - 1'b1 : rem_reg;
        priority if (held_reg == wbxat_pkg::TokEntity) begin
            mbi_kind = wbxat_pkg::KIND_ENTITY;
        end else if (held_reg == wbxat_pkg::TokLiteral) begin
            mbi_kind = wbxat_pkg::KIND_LITERAL;
        end else if (held_reg == wbxat_pkg::TokStrT) begin
            mbi_kind = wbxat_pkg::KIND_STR_T;
        end else if (held_reg == wbxat_pkg::TokOpaque) begin
            mbi_kind = wbxat_pkg::KIND_OPAQUE;
        end else begin
            mbi_kind = wbxat_pkg::KIND_EXT_T;
        end
    end

    always_comb begin
        phase_next = phase_eff;
        held_next  = held_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        page_next  = page_reg;
        tally_next = tally_reg;
        cnt_next   = cnt_reg;

        result.valid = 1'b0;
        result.kind  = wbxat_pkg::KIND_INVALID;
        result.code  = held_reg;
        result.value = '0;
        result.page  = page_reg;
        result.bytes = tally_inc;
        result.done  = 1'b0;

        unique case (phase_eff)
            wbxat_pkg::PH_IDLE: begin
                held_next    = data_byte;
                tally_next   = {{(wbxat_pkg::TallyWidth-1){1'b0}}, 1'b1};
                acc_next     = '0;
                rem_next     = '0;
                cnt_next     = '0;
                result.code  = data_byte;
                result.bytes = {{(wbxat_pkg::TallyWidth-1){1'b0}}, 1'b1};
                if (data_byte[5:0] >= wbxat_pkg::AttrCodeMin) begin
                    result.valid = 1'b1;
                    result.kind  = data_byte[7] ? wbxat_pkg::KIND_ATTR_VALUE
                                                : wbxat_pkg::KIND_ATTR_START;
                end else begin
                    unique case (data_byte)
                        wbxat_pkg::TokSwitchPage: begin
                            phase_next = wbxat_pkg::PH_PAGE;
                        end
                        wbxat_pkg::TokEnd: begin
                            phase_next   = wbxat_pkg::PH_STOPPED;
                            result.valid = 1'b1;
                            result.kind  = wbxat_pkg::KIND_END;
                            result.done  = 1'b1;
                        end
                        wbxat_pkg::TokEntity, wbxat_pkg::TokLiteral,
                        wbxat_pkg::TokExtT0, wbxat_pkg::TokExtT1,
                        wbxat_pkg::TokExtT2, wbxat_pkg::TokStrT: begin
                            phase_next = wbxat_pkg::PH_MBI;
                        end
                        wbxat_pkg::TokStrI, wbxat_pkg::TokExtI0,
                        wbxat_pkg::TokExtI1, wbxat_pkg::TokExtI2: begin
                            phase_next = wbxat_pkg::PH_STR;
                        end
                        wbxat_pkg::TokExt0, wbxat_pkg::TokExt1,
                        wbxat_pkg::TokExt2: begin
                            result.valid = 1'b1;
                            result.kind  = wbxat_pkg::KIND_EXT_SINGLE;
                        end
                        wbxat_pkg::TokOpaque: begin
                            if (version_above_one_zero) begin
                                phase_next = wbxat_pkg::PH_MBI;
                            end else begin
                                phase_next   = wbxat_pkg::PH_STOPPED;
                                result.valid = 1'b1;
                                result.kind  = wbxat_pkg::KIND_RESERVED;
                                result.done  = 1'b1;
                            end
                        end
                        default: begin
                            phase_next   = wbxat_pkg::PH_STOPPED;
                            result.valid = 1'b1;
                            result.kind  = wbxat_pkg::KIND_INVALID;
                            result.done  = 1'b1;
                        end
                    endcase
                end
            end
            wbxat_pkg::PH_PAGE: begin
                tally_next   = tally_inc;
                page_next    = data_byte;
                phase_next   = wbxat_pkg::PH_IDLE;
                result.valid = 1'b1;
                result.kind  = wbxat_pkg::KIND_SWITCH_PAGE;
                result.value = {{(wbxat_pkg::ValueWidth-wbxat_pkg::DataWidth){1'b0}},
                                data_byte};
                result.page  = data_byte;
            end
            wbxat_pkg::PH_MBI: begin
                tally_next = tally_inc;
                acc_next   = acc_shift;
                cnt_next   = cnt_inc;
                if (data_byte[7] && (cnt_inc < wbxat_pkg::MbiMaxBytes)) begin
                    phase_next = wbxat_pkg::PH_MBI;
                end else if ((held_reg == wbxat_pkg::TokOpaque) && (acc_shift != '0)) begin
                    rem_next   = acc_shift;
                    phase_next = wbxat_pkg::PH_SKIP;
                end else begin
                    phase_next   = wbxat_pkg::PH_IDLE;
                    result.valid = 1'b1;
                    result.kind  = mbi_kind;
                    result.value = acc_shift;
                end
            end
            wbxat_pkg::PH_STR: begin
                tally_next = tally_inc;
                if (data_byte == '0) begin
                    phase_next   = wbxat_pkg::PH_IDLE;
                    result.valid = 1'b1;
                    result.kind  = (held_reg == wbxat_pkg::TokStrI)
                                   ? wbxat_pkg::KIND_STR_I : wbxat_pkg::KIND_EXT_I;
                end
            end
            wbxat_pkg::PH_SKIP: begin
                tally_next = tally_inc;
                rem_next   = rem_dec;
                if (rem_dec == '0) begin
                    phase_next   = wbxat_pkg::PH_IDLE;
                    result.valid = 1'b1;
                    result.kind  = wbxat_pkg::KIND_OPAQUE;
                    result.value = acc_reg;
                end
            end
            default: begin
                phase_next = wbxat_pkg::PH_STOPPED;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= wbxat_pkg::PH_STOPPED;
            held_reg  <= '0;
            acc_reg   <= '0;
            rem_reg   <= '0;
            page_reg  <= '0;
            tally_reg <= '0;
            cnt_reg   <= '0;
        end else if (advance) begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            acc_reg   <= acc_next;
            rem_reg   <= rem_next;
            page_reg  <= page_next;
            tally_reg <= tally_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire
